@@ src/ucb1_pkg.sv @@
// ucb1_pkg: shared constants for the ucb1 arm selector
// no dependencies
package ucb1_pkg;
    localparam int NumArmsDefault = 16;
    localparam int ArmW   = 4;
    localparam int CountW = 5;
    localparam int SumW   = 48;
    localparam int PullW  = 32;
    localparam int RewW   = 32;
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] RegArmCount = 1'd0;
    localparam logic [CfgIdxW-1:0] RegEvalTime = 1'd1;
    localparam logic [63:0] Ln2Q32 = 64'd2977044472;
    localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
endpackage

@@ src/ucb1_if.sv @@
// ucb1 handshake channel interfaces
// uses no package
interface ucb1_rew_if;
    logic        valid;
    logic        ready;
    logic [31:0] tick_reward;
    modport source (output valid, output tick_reward, input ready);
    modport sink   (input valid, input tick_reward, output ready);
endinterface

interface ucb1_arm_if;
    logic       valid;
    logic       ready;
    logic [3:0] chosen_arm;
    modport source (output valid, output chosen_arm, input ready);
    modport sink   (input valid, input chosen_arm, output ready);
endinterface

interface ucb1_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/ucb1_alu.sv @@
// ucb1_alu: shared 64-bit restoring divider / square root unit, one bit a cycle
// depends on nothing
module ucb1_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sqrt,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_sq, n_sq, r_done, n_done;
    logic [64:0] w_trial;
    logic [64:0] w_shift;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_a = r_a; n_b = r_b; n_cnt = r_cnt;
        n_busy = r_busy; n_sq = r_sq; n_done = 1'b0;
        w_shift = '0; w_trial = '0;
        if (i_start) begin
            n_q = '0; n_rem = '0; n_a = i_a; n_b = i_b; n_sq = i_sqrt;
            n_cnt = i_sqrt ? 7'd32 : 7'd64; n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_sq) begin
                // digit-by-digit root: bring down two bits
                w_shift = {r_rem[62:0], r_a[63:62]};
                w_trial = {r_q[62:0], 2'b01};
                n_a = {r_a[61:0], 2'b00};
                if (w_shift >= w_trial) begin
                    n_rem = w_shift - w_trial;
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = w_shift;
                    n_q = {r_q[62:0], 1'b0};
                end
            end else begin
                w_shift = {r_rem[63:0], r_a[63]};
                w_trial = {1'b0, r_b};
                n_a = {r_a[62:0], 1'b0};
                if (w_shift >= w_trial) begin
                    n_rem = w_shift - w_trial;
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = w_shift;
                    n_q = {r_q[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_rem <= n_rem; r_a <= n_a; r_b <= n_b; r_cnt <= n_cnt; r_sq <= n_sq;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_q;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_start) |=> !r_busy) else $error("unit woke itself");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start ignored");
`endif
endmodule

@@ src/ucb1_bandit_arm_selector_core.sv @@
// ucb1_bandit_arm_selector_core: top level, sequencer and arm stores
// depends on ucb1_pkg, ucb1_if and ucb1_alu
//
// Each accepted tick adds its Q16.16 reward to the current arm's saturating sum;
// mid-epoch ticks are accepted back to back. At the end of an epoch the block
// stops accepting ticks and selects the next arm. If an arm has never been
// pulled, the first such arm is chosen. Otherwise it walks the arms through one
// shared 64-bit divide/square-root unit (one bit per cycle): a log2 of the total
// pull count (16 squaring steps on a 32x32 multiplier), then per arm one 64-step
// mean division, one 64-step radius division and one 32-step square root. The
// chosen arm is then offered on the output channel; the next tick is taken once
// that result has been sent. Register writes are taken only between selections
// and hold off a tick in the same cycle. Writing arm_count clears all sums and
// pull counts.
module ucb1_bandit_arm_selector_core #(
    parameter int NUM_ARMS = ucb1_pkg::NumArmsDefault
) (
    input logic i_clk,
    input logic i_rst_n,
    ucb1_rew_if.sink   i_rew,
    ucb1_arm_if.source o_arm,
    ucb1_cfg_if.sink   i_cfg
);
    localparam int AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
    localparam int SW = ucb1_pkg::SumW;

    localparam logic [3:0] S_TICK = 4'd0, S_SCAN = 4'd1, S_LOGN = 4'd2, S_LOGS = 4'd3,
        S_NOM = 4'd4, S_MEAN = 4'd5, S_MEANW = 4'd6, S_RAD = 4'd7, S_RADW = 4'd8,
        S_SQ = 4'd9, S_SQW = 4'd10, S_CMP = 4'd11, S_OUT = 4'd12;

    logic [SW-1:0] r_sum [NUM_ARMS];
    logic [31:0]   r_pull [NUM_ARMS];
    logic [NUM_ARMS-1:0] r_vld;
    logic [31:0] r_ticks, r_eval;
    logic [ucb1_pkg::CountW-1:0] r_cnt;
    logic [AW-1:0] r_cur, r_idx, r_best;
    logic [3:0]  r_st;
    logic [63:0] r_total, r_nom, r_mean, r_best_sc;
    logic [31:0] r_m;
    logic [4:0]  r_li;
    logic [15:0] r_lres;
    logic [5:0]  r_k;
    logic        r_neg, r_have;
    logic [3:0]  r_out;

    logic        w_acc, w_cfg, w_end;
    logic [AW-1:0] w_arm;
    logic [SW-1:0] w_s;
    logic [31:0] w_p;
    logic [SW:0] w_add;
    logic [SW-1:0] w_sat, w_mag;
    logic [31:0] w_pinc;
    logic        w_start, w_sqrt, w_done;
    logic [63:0] w_a, w_b, w_res, w_score, w_norm;
    logic [31:0] w_mx, w_my, w_sqm;
    logic [63:0] w_prod;
    logic [4:0]  w_lim;

    assign w_lim = (r_cnt > ucb1_pkg::CountW'(NUM_ARMS)) ? ucb1_pkg::CountW'(NUM_ARMS) : r_cnt;
    assign w_arm = (32'(r_cur) < 32'(w_lim)) ? r_cur : '0;
    assign w_s = r_vld[w_arm] ? r_sum[w_arm] : '0;
    assign w_p = r_vld[w_arm] ? r_pull[w_arm] : '0;
    assign w_add = {w_s[SW-1], w_s} + {{(SW-31){i_rew.tick_reward[31]}}, i_rew.tick_reward};
    always_comb begin
        w_sat = w_add[SW-1:0];
        if (w_add[SW] != w_add[SW-1]) w_sat = w_add[SW] ? ucb1_pkg::SumMin : ucb1_pkg::SumMax;
    end
    assign w_pinc = (w_p == 32'hFFFFFFFF) ? w_p : w_p + 32'd1;
    assign w_end = !(33'(r_ticks) + 33'd1 < 33'(r_eval));

    // per-arm values at the scan index
    logic [SW-1:0] w_is;
    logic [31:0]   w_ip;
    assign w_is = r_vld[r_idx] ? r_sum[r_idx] : '0;
    assign w_ip = r_vld[r_idx] ? r_pull[r_idx] : '0;
    assign w_mag = w_is[SW-1] ? (~w_is + 1'b1) : w_is;

    assign w_acc = i_rew.valid && i_rew.ready;
    assign w_cfg = i_cfg.valid && i_cfg.ready;
    assign i_rew.ready = (r_st == S_TICK) && !i_cfg.valid;
    assign i_cfg.ready = (r_st == S_TICK);
    assign o_arm.valid = (r_st == S_OUT);
    assign o_arm.chosen_arm = r_out;

    // squaring step for log2 and nom product (shared 32x32 multiplier)
    assign w_mx = (r_st == S_NOM) ? r_nom[31:0] : r_m;
    assign w_my = (r_st == S_NOM) ? ucb1_pkg::Ln2Q32[31:0] : r_m;
    assign w_prod = {32'd0, w_mx} * {32'd0, w_my};
    assign w_sqm = w_prod[61:30];

    assign w_start = (r_st == S_MEAN) || (r_st == S_RAD) || (r_st == S_SQ);
    assign w_sqrt = (r_st == S_SQ);
    assign w_a = (r_st == S_MEAN) ? {16'd0, w_mag} : (r_st == S_RAD) ? r_nom : r_mean;
    assign w_b = {32'd0, w_ip};
    assign w_score = r_mean + w_res;

    ucb1_alu u_alu (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_sqrt(w_sqrt),
        .i_a(w_a), .i_b(w_b), .o_done(w_done), .o_res(w_res));

    // index of top set bit of total
    logic [5:0] w_top;
    always_comb begin
        w_top = '0;
        for (int b = 0; b < 64; b++) if (r_total[b]) w_top = 6'(b);
    end
    assign w_norm = (w_top <= 6'd30) ? (r_total << (6'd30 - w_top))
                                     : (r_total >> (w_top - 6'd30));

    logic [63:0] r_rmean;
    always_ff @(posedge i_clk) begin
        if (w_acc && r_cnt != '0) begin
            r_sum[w_arm] <= w_sat;
            r_pull[w_arm] <= w_end ? w_pinc : w_p;
        end
        if (!i_rst_n) begin
            r_vld <= '0; r_ticks <= '0; r_cur <= '0; r_cnt <= '0; r_eval <= '1;
            r_st <= S_TICK;
        end else if (w_cfg) begin
            if (i_cfg.index == ucb1_pkg::RegArmCount) begin
                r_cnt <= (i_cfg.data[4:0] > 5'(NUM_ARMS)) ? 5'(NUM_ARMS) : i_cfg.data[4:0];
                r_vld <= '0; r_ticks <= '0; r_cur <= '0;
            end else r_eval <= i_cfg.data;
        end else begin
            unique case (r_st)
                S_TICK: if (w_acc && r_cnt != '0) begin
                    r_vld[w_arm] <= 1'b1;
                    if (!w_end) r_ticks <= r_ticks + 32'd1;
                    else begin
                        r_ticks <= '0; r_idx <= '0; r_total <= '0; r_st <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_ip == '0) begin
                        r_cur <= r_idx; r_out <= 4'(r_idx); r_st <= S_OUT;
                    end else begin
                        r_total <= r_total + {32'd0, w_ip};
                        if (5'(r_idx) + 5'd1 >= w_lim) r_st <= S_LOGN;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                S_LOGN: begin
                    r_k <= w_top;
                    r_m <= w_norm[31:0];
                    r_li <= 5'd16; r_lres <= '0; r_st <= S_LOGS;
                end
                S_LOGS: begin
                    if (r_li == '0) begin
                        r_nom <= {42'd0, r_k, r_lres}; r_st <= S_NOM;
                    end else begin
                        if (w_sqm[31]) begin
                            r_lres[4'(r_li - 5'd1)] <= 1'b1; r_m <= {1'b0, w_sqm[31:1]};
                        end else r_m <= w_sqm;
                        r_li <= r_li - 5'd1;
                    end
                end
                S_NOM: begin
                    r_nom <= {15'd0, w_prod[63:15]}; r_idx <= '0; r_have <= 1'b0;
                    r_st <= S_MEAN;
                end
                S_MEAN: begin r_neg <= w_is[SW-1]; r_st <= S_MEANW; end
                S_MEANW: if (w_done) begin
                    r_rmean <= r_neg ? (~w_res + 64'd1) : w_res; r_st <= S_RAD;
                end
                S_RAD: r_st <= S_RADW;
                S_RADW: if (w_done) begin r_mean <= w_res; r_st <= S_SQ; end
                S_SQ: r_st <= S_SQW;
                S_SQW: if (w_done) begin r_mean <= r_rmean; r_st <= S_CMP; end
                S_CMP: begin
                    if (!r_have || $signed(w_score) > $signed(r_best_sc)) begin
                        r_have <= 1'b1; r_best_sc <= w_score; r_best <= r_idx;
                    end
                    if (5'(r_idx) + 5'd1 >= w_lim) begin
                        r_st <= S_OUT;
                        if (!r_have || $signed(w_score) > $signed(r_best_sc)) begin
                            r_cur <= r_idx; r_out <= 4'(r_idx);
                        end else begin
                            r_cur <= r_best; r_out <= 4'(r_best);
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1; r_st <= S_MEAN;
                    end
                end
                S_OUT: if (o_arm.ready) r_st <= S_TICK;
                default: r_st <= S_TICK;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_TICK) |-> !i_rew.ready) else $error("tick taken during selection");
    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_arm.valid |-> (32'(r_cur) < 32'(w_lim))) else $error("chosen arm out of range");
    a_ticks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCAN) |-> (r_ticks == '0)) else $error("epoch count not cleared");
`endif
endmodule
